>>> hdl/round_robin_sleep_scheduler_core_macros.svh
// ----------------------------------------------------------------------------
// Round-robin sleep scheduler assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_SLEEP_SCHEDULER_CORE_MACROS_SVH
`define ROUND_ROBIN_SLEEP_SCHEDULER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RRSS_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RRSS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/rrss_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin sleep scheduler package
// Beat types, codes and controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package rrss_pkg;

   localparam int NUM_SLOTS_DEF = 16;
   localparam int SLOT_FIELD_W  = 4;
   localparam int TICK_W        = 32;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_SLEEP  = 2'd2,
      ACT_TICK   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_OK   = 2'd0,
      STS_FULL = 2'd1,
      STS_NONE = 2'd2,
      STS_FREE = 2'd3
   } status_type;

   typedef struct packed {
      action_type              action;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [TICK_W-1:0]       wake_at;
      logic [TICK_W-1:0]       now_tick;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [SLOT_FIELD_W-1:0] new_slot;
      logic                    has_current;
      logic [SLOT_FIELD_W-1:0] current_slot;
      logic                    switched;
   } rsp_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_DECODE,
      CS_SCAN,
      CS_FINISH
   } ctrl_state_type;

   typedef enum logic [1:0] {
      SCAN_FREE,
      SCAN_RUN,
      SCAN_TICK
   } scan_mode_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_ADD,
      KIND_REMOVE,
      KIND_TICK
   } commit_kind_type;

   typedef struct packed {
      logic            load;
      logic            scan_start;
      scan_mode_type   scan_mode;
      logic            sleep_wr;
      logic            remove_clr;
      logic            commit;
      commit_kind_type kind;
      status_type      status;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       slot_ok;
      logic       is_current;
      logic       scan_done;
      logic       found;
   } sts_type;

endpackage

>>> hdl/rrss_ctrl.sv
// ----------------------------------------------------------------------------
// Round-robin sleep scheduler controller
// Sequences accept, decode, slot scan and result commit for one beat at a time.
// ----------------------------------------------------------------------------
`include "round_robin_sleep_scheduler_core_macros.svh"

module rrss_ctrl
   import rrss_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   ctrl_state_type  state_ff, state_in;
   commit_kind_type kind_ff, kind_in;
   status_type      status_ff, status_in;
   logic            rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         kind_ff      <= KIND_NONE;
         status_ff    <= STS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      status_in      = status_ff;
      cmd            = '0;
      cmd.scan_mode  = SCAN_FREE;
      cmd.kind       = kind_ff;
      cmd.status     = status_ff;
      case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CS_DECODE;
            end
         end
         CS_DECODE: begin
            status_in = STS_OK;
            kind_in   = KIND_NONE;
            state_in  = CS_FINISH;
            case (sts.action)
               ACT_ADD: begin
                  cmd.scan_start = 1'b1;
                  cmd.scan_mode  = SCAN_FREE;
                  kind_in        = KIND_ADD;
                  state_in       = CS_SCAN;
               end
               ACT_TICK: begin
                  cmd.scan_start = 1'b1;
                  cmd.scan_mode  = SCAN_TICK;
                  kind_in        = KIND_TICK;
                  state_in       = CS_SCAN;
               end
               ACT_SLEEP: begin
                  if (sts.slot_ok) begin
                     cmd.sleep_wr = 1'b1;
                  end else begin
                     status_in = STS_FREE;
                  end
               end
               ACT_REMOVE: begin
                  if (!sts.slot_ok) begin
                     status_in = STS_FREE;
                  end else begin
                     cmd.remove_clr = 1'b1;
                     // losing the current task: look for the next runnable one
                     if (sts.is_current) begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = SCAN_RUN;
                        kind_in        = KIND_REMOVE;
                        state_in       = CS_SCAN;
                     end
                  end
               end
               default: ;
            endcase
         end
         CS_SCAN: begin
            if (sts.scan_done) begin
               state_in = CS_FINISH;
            end
         end
         CS_FINISH: begin
            case (kind_ff)
               KIND_ADD:  cmd.status = sts.found ? STS_OK : STS_FULL;
               KIND_TICK: cmd.status = sts.found ? STS_OK : STS_NONE;
               default:   cmd.status = status_ff;
            endcase
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.commit = 1'b1;
               state_in   = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign req_stall    = (state_ff != CS_IDLE);

   `RRSS_ASSERT_NOW(a_commit_free, cmd.commit, !rsp_valid_ff || !rsp_stall, "result overwritten")
   `RRSS_ASSERT_NEXT(a_accept_decode, req_valid && !req_stall, state_ff == CS_DECODE, "accept lost")
   `RRSS_ASSERT_NOW(a_done_in_scan, sts.scan_done, state_ff == CS_SCAN, "scan done out of place")

endmodule

>>> hdl/rrss_dpath.sv
// ----------------------------------------------------------------------------
// Round-robin sleep scheduler datapath
// Slot flags, wake-up tick memory, one-slot-per-cycle scanner, current task.
// ----------------------------------------------------------------------------
`include "round_robin_sleep_scheduler_core_macros.svh"

module rrss_dpath
   import rrss_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req_payload,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_payload
);

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(NUM_SLOTS);

   req_type             item_ff;
   logic [NUM_SLOTS-1:0] in_use_ff, in_use_in;
   logic [NUM_SLOTS-1:0] asleep_ff, asleep_in;
   logic [TICK_W-1:0]   wake_mem [NUM_SLOTS];
   logic [TICK_W-1:0]   rd_wake_ff;
   logic [SLOT_W-1:0]   running_ff, running_in;
   logic                running_vld_ff, running_vld_in;
   logic                scan_busy_ff;
   scan_mode_type       scan_mode_ff;
   logic [SLOT_W-1:0]   scan_idx_ff;
   logic [CNT_W-1:0]    scan_cnt_ff;
   logic                ev_vld_ff;
   logic [SLOT_W-1:0]   ev_slot_ff;
   logic                found_ff;
   logic [SLOT_W-1:0]   pick_ff;
   rsp_type             rsp_ff, rsp_in;

   logic [SLOT_W-1:0]   slot_idx;
   logic                slot_in_range;
   logic [SLOT_W-1:0]   start_idx;
   logic                ev_in_use, ev_asleep, ev_due, ev_hit;
   logic                scan_done;
   logic                commit_add;
   logic                switched;
   logic [SLOT_FIELD_W-1:0] new_slot;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      return (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
   endfunction

   assign slot_idx      = SLOT_W'(item_ff.slot);
   assign slot_in_range = 32'(item_ff.slot) < 32'(NUM_SLOTS);

   assign sts.action     = item_ff.action;
   assign sts.slot_ok    = slot_in_range && in_use_ff[slot_idx];
   assign sts.is_current = running_vld_ff && (running_ff == slot_idx);
   assign sts.scan_done  = scan_done;
   assign sts.found      = found_ff;

   assign scan_done = scan_busy_ff && (scan_cnt_ff == CNT_FULL) && !ev_vld_ff;

   always_comb begin
      case (cmd.scan_mode)
         SCAN_RUN:  start_idx = next_slot(slot_idx);
         SCAN_TICK: start_idx = running_vld_ff ? next_slot(running_ff) : '0;
         default:   start_idx = '0;
      endcase
   end

   // evaluate the slot whose wake tick was read last cycle
   assign ev_in_use = in_use_ff[ev_slot_ff];
   assign ev_asleep = asleep_ff[ev_slot_ff];
   assign ev_due    = (scan_mode_ff == SCAN_TICK) && ev_in_use && ev_asleep &&
                      (rd_wake_ff <= item_ff.now_tick);

   always_comb begin
      case (scan_mode_ff)
         SCAN_FREE: ev_hit = !ev_in_use;
         SCAN_RUN:  ev_hit = ev_in_use && !ev_asleep;
         SCAN_TICK: ev_hit = ev_in_use && (!ev_asleep || ev_due);
         default:   ev_hit = 1'b0;
      endcase
   end

   assign commit_add = cmd.commit && (cmd.kind == KIND_ADD) && found_ff;

   always_comb begin
      in_use_in = in_use_ff;
      asleep_in = asleep_ff;
      if (cmd.sleep_wr) begin
         asleep_in[slot_idx] = 1'b1;
      end
      if (cmd.remove_clr) begin
         in_use_in[slot_idx] = 1'b0;
         asleep_in[slot_idx] = 1'b0;
      end
      if (ev_vld_ff && ev_due) begin
         asleep_in[ev_slot_ff] = 1'b0;
      end
      if (commit_add) begin
         in_use_in[pick_ff] = 1'b1;
         asleep_in[pick_ff] = 1'b0;
      end
   end

   always_comb begin
      running_in     = running_ff;
      running_vld_in = running_vld_ff;
      switched       = 1'b0;
      new_slot       = '0;
      if (cmd.commit) begin
         case (cmd.kind)
            KIND_ADD: begin
               if (found_ff) begin
                  new_slot = SLOT_FIELD_W'(pick_ff);
                  if (!running_vld_ff) begin
                     running_in     = pick_ff;
                     running_vld_in = 1'b1;
                     switched       = 1'b1;
                  end
               end
            end
            KIND_REMOVE: begin
               switched = 1'b1;
               if (found_ff) begin
                  running_in = pick_ff;
               end else begin
                  running_in     = '0;
                  running_vld_in = 1'b0;
               end
            end
            KIND_TICK: begin
               if (found_ff && (!running_vld_ff || (pick_ff != running_ff))) begin
                  running_in     = pick_ff;
                  running_vld_in = 1'b1;
                  switched       = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_in.status       = cmd.status;
      rsp_in.new_slot     = new_slot;
      rsp_in.has_current  = running_vld_in;
      rsp_in.current_slot = running_vld_in ? SLOT_FIELD_W'(running_in) : '0;
      rsp_in.switched     = switched;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff      <= '0;
         asleep_ff      <= '0;
         running_ff     <= '0;
         running_vld_ff <= 1'b0;
         scan_busy_ff   <= 1'b0;
         ev_vld_ff      <= 1'b0;
         found_ff       <= 1'b0;
      end else begin
         in_use_ff      <= in_use_in;
         asleep_ff      <= asleep_in;
         running_ff     <= running_in;
         running_vld_ff <= running_vld_in;
         if (cmd.scan_start) begin
            scan_busy_ff <= 1'b1;
            found_ff     <= 1'b0;
            ev_vld_ff    <= 1'b0;
         end else if (scan_busy_ff) begin
            ev_vld_ff <= (scan_cnt_ff != CNT_FULL);
            // keep the first hit in scan order
            if (ev_vld_ff && ev_hit && !found_ff) begin
               found_ff <= 1'b1;
            end
            if (scan_done) begin
               scan_busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_payload;
      end
      if (cmd.scan_start) begin
         scan_mode_ff <= cmd.scan_mode;
         scan_idx_ff  <= start_idx;
         scan_cnt_ff  <= '0;
      end else if (scan_busy_ff && (scan_cnt_ff != CNT_FULL)) begin
         ev_slot_ff  <= scan_idx_ff;
         scan_idx_ff <= next_slot(scan_idx_ff);
         scan_cnt_ff <= scan_cnt_ff + CNT_W'(1);
      end
      if (scan_busy_ff && ev_vld_ff && ev_hit && !found_ff) begin
         pick_ff <= ev_slot_ff;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sleep_wr) begin
         wake_mem[slot_idx] <= item_ff.wake_at;
      end
      rd_wake_ff <= wake_mem[scan_idx_ff];
   end

   assign rsp_payload = rsp_ff;

   // a removed current task stays current until its replacement scan commits
   `RRSS_ASSERT_NOW(a_run_in_use, running_vld_ff && (cmd.kind != KIND_REMOVE), in_use_ff[running_ff], "current slot not in use")
   `RRSS_ASSERT_NOW(a_sleep_in_use, 1'b1, (asleep_ff & ~in_use_ff) == '0, "free slot asleep")
   `RRSS_ASSERT_NOW(a_scan_cnt_range, scan_busy_ff, scan_cnt_ff <= CNT_FULL, "scan count overrun")

endmodule

>>> hdl/round_robin_sleep_scheduler_core.sv
// Add, tick and removal of the current task run a scan over every slot between accept
// and result; sleep, other removals and rejected sleeps or removals skip the scan.
// Throughput: one item at a time; the slot scanner visits one slot per cycle.
// Reset (synchronous, active high) frees all slots and clears the current task.
// ----------------------------------------------------------------------------
// Round-robin sleep scheduler core
// Task slot table with sleep time-outs and cyclic selection of the current task.
// ----------------------------------------------------------------------------
module round_robin_sleep_scheduler_core
   import rrss_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   cmd_type cmd;
   sts_type sts;

   rrss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rrss_dpath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> tb/tb_round_robin_sleep_scheduler_core.sv
// ----------------------------------------------------------------------------
// Round-robin sleep scheduler core testbench
// Drives add, remove, sleep and tick requests through the request channel. A
// scheduler model tracks slots, sleepers and the current task, and every
// response is checked against its prediction. Senders burst, receivers stall.
// ----------------------------------------------------------------------------
module tb_round_robin_sleep_scheduler_core;
   import rrss_pkg::*;

   localparam int SLOT_COUNT   = NUM_SLOTS_DEF;
   localparam int RANDOM_ITEMS = 1500;
   localparam int MAX_REPORTS  = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   round_robin_sleep_scheduler_core #(.NUM_SLOTS(SLOT_COUNT)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // Scheduler model state
   bit          task_in_use [SLOT_COUNT];
   bit          task_asleep [SLOT_COUNT];
   logic [31:0] task_wake   [SLOT_COUNT];
   logic [3:0]  cur_slot;
   bit          cur_valid;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];

   int reqs_accepted;
   int rsps_checked;
   int switches_seen;
   int status_seen [4];
   int mismatches;

   function automatic bit task_ready(int s);
      return task_in_use[s] && !task_asleep[s];
   endfunction

   // Next ready slot strictly after 'from' in cyclic order, -1 if none.
   function automatic int next_ready_after(int from);
      for (int i = 1; i < SLOT_COUNT; i++) begin
         int s;
         s = (from + i) % SLOT_COUNT;
         if (task_ready(s)) return s;
      end
      return -1;
   endfunction

   function automatic rsp_type schedule_step(req_type r);
      rsp_type o;
      int      pick;
      o = '0;
      o.status = STS_OK;
      pick = -1;
      case (r.action)
         ACT_ADD: begin
            for (int s = 0; s < SLOT_COUNT; s++)
               if (!task_in_use[s] && pick < 0) pick = s;
            if (pick < 0) begin
               o.status = STS_FULL;
            end else begin
               task_in_use[pick] = 1'b1;
               task_asleep[pick] = 1'b0;
               task_wake[pick]   = '0;
               o.new_slot = 4'(pick);
               if (!cur_valid) begin
                  cur_valid  = 1'b1;
                  cur_slot   = 4'(pick);
                  o.switched = 1'b1;
               end
            end
         end
         ACT_REMOVE, ACT_SLEEP: begin
            if (int'(r.slot) >= SLOT_COUNT || !task_in_use[r.slot]) begin
               o.status = STS_FREE;
            end else if (r.action == ACT_SLEEP) begin
               task_asleep[r.slot] = 1'b1;
               task_wake[r.slot]   = r.wake_at;
            end else begin
               task_in_use[r.slot] = 1'b0;
               task_asleep[r.slot] = 1'b0;
               if (cur_valid && cur_slot == r.slot) begin
                  o.switched = 1'b1;
                  pick = next_ready_after(r.slot);
                  if (pick >= 0) begin
                     cur_slot = 4'(pick);
                  end else begin
                     cur_valid = 1'b0;
                     cur_slot  = '0;
                  end
               end
            end
         end
         default: begin
            for (int s = 0; s < SLOT_COUNT; s++)
               if (task_in_use[s] && task_asleep[s] && task_wake[s] <= r.now_tick)
                  task_asleep[s] = 1'b0;
            if (cur_valid) begin
               pick = next_ready_after(cur_slot);
               if (pick < 0 && task_ready(cur_slot)) pick = cur_slot;
            end else begin
               for (int s = 0; s < SLOT_COUNT; s++)
                  if (task_ready(s) && pick < 0) pick = s;
            end
            if (pick < 0) begin
               o.status = STS_NONE;
            end else if (!cur_valid || 4'(pick) != cur_slot) begin
               cur_valid  = 1'b1;
               cur_slot   = 4'(pick);
               o.switched = 1'b1;
            end
         end
      endcase
      o.has_current  = cur_valid;
      o.current_slot = cur_valid ? cur_slot : 4'd0;
      return o;
   endfunction

   // Driver: bursts of beats from the pending queue, random gaps in between
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= $urandom_range(1, 24);
         gap_left   <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(schedule_step(req_payload));
            reqs_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left  <= gap_left - 1;
            end else if (pending_reqs.size() > 0) begin
               req_valid   <= 1'b1;
               req_payload <= pending_reqs.pop_front();
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(string what, rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("MISMATCH %s: exp sts=%0d new=%0d cur=%0d/%0d sw=%0d",
                  what, want.status, want.new_slot, want.has_current, want.current_slot,
                  want.switched);
         $display("   got sts=%0d new=%0d cur=%0d/%0d sw=%0d",
                  got.status, got.new_slot, got.has_current, got.current_slot,
                  got.switched);
      end
   endtask

   // Monitor: own stall pattern, check each accepted response beat
   logic [9:0] stall_phase = '0;

   always @(posedge clock) begin
      rsp_type want;
      bit      bad;
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_phase <= '0;
      end else begin
         stall_phase <= stall_phase + 10'd1;
         case (stall_phase[9:8])
            2'd0:    rsp_stall <= 1'b0;
            2'd1:    rsp_stall <= ($urandom_range(0, 1) == 1);
            2'd2:    rsp_stall <= ($urandom_range(0, 9) < 8);
            default: rsp_stall <= (stall_phase[2:0] < 3'd3);
         endcase
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected beat", '0, rsp_payload);
            end else begin
               want = expected_rsps.pop_front();
               bad = (rsp_payload.status !== want.status)
                  || (rsp_payload.new_slot !== want.new_slot)
                  || (rsp_payload.has_current !== want.has_current)
                  || (rsp_payload.current_slot !== want.current_slot)
                  || (rsp_payload.switched !== want.switched);
               if (bad) report_mismatch("field", want, rsp_payload);
               rsps_checked++;
               status_seen[want.status]++;
               if (want.switched) switches_seen++;
            end
         end
      end
   end

   // Stimulus
   logic [31:0] gen_now = '0;

   task automatic queue_req(action_type a, logic [3:0] s, logic [31:0] w, logic [31:0] t);
      req_type r;
      r.action   = a;
      r.slot     = s;
      r.wake_at  = w;
      r.now_tick = t;
      pending_reqs.push_back(r);
   endtask

   task automatic queue_add();
      queue_req(ACT_ADD, 4'($urandom), $urandom, $urandom);
   endtask

   task automatic queue_remove();
      queue_req(ACT_REMOVE, 4'($urandom_range(0, SLOT_COUNT - 1)), $urandom, $urandom);
   endtask

   task automatic queue_sleep();
      logic [31:0] w;
      case ($urandom_range(0, 15))
         0:       w = '0;
         1:       w = '1;
         2:       w = $urandom;
         default: w = gen_now + $urandom_range(0, 120);
      endcase
      queue_req(ACT_SLEEP, 4'($urandom_range(0, SLOT_COUNT - 1)), w, $urandom);
   endtask

   task automatic queue_tick();
      if ($urandom_range(0, 31) == 0) gen_now = $urandom;
      else gen_now = gen_now + $urandom_range(0, 40);
      queue_req(ACT_TICK, 4'($urandom), $urandom, gen_now);
   endtask

   task automatic queue_any();
      case ($urandom_range(0, 9))
         0, 1, 2:    queue_add();
         3, 4:       queue_remove();
         5, 6:       queue_sleep();
         default:    queue_tick();
      endcase
   endtask

   initial begin
      int base;

      // Directed: empty table, stale slots, fill to full, sleep the current task
      queue_req(ACT_TICK, 4'd0, 32'd0, 32'd0);
      queue_req(ACT_REMOVE, 4'd15, 32'd0, 32'd0);
      queue_req(ACT_SLEEP, 4'd0, 32'hFFFF_FFFF, 32'd0);
      repeat (SLOT_COUNT) queue_req(ACT_ADD, 4'd0, 32'd0, 32'd0);
      queue_req(ACT_ADD, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_req(ACT_SLEEP, 4'd0, 32'hFFFF_FFFF, 32'd0);
      queue_req(ACT_SLEEP, 4'd15, 32'd0, 32'd0);
      queue_req(ACT_TICK, 4'd0, 32'd0, 32'd0);
      queue_req(ACT_REMOVE, 4'd1, 32'd0, 32'd0);
      queue_req(ACT_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF);

      // Random: fill, drain, sleep-then-tick runs, noise and mixed single ops
      base = pending_reqs.size();
      while (pending_reqs.size() - base < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: repeat ($urandom_range(4, 18)) queue_add();
            1: repeat ($urandom_range(4, 20)) queue_remove();
            2, 3: begin
               repeat ($urandom_range(1, 6)) queue_sleep();
               repeat ($urandom_range(1, 6)) queue_tick();
            end
            4: queue_req(action_type'($urandom_range(0, 3)), 4'($urandom), $urandom, $urandom);
            default: repeat ($urandom_range(1, 8)) queue_any();
         endcase
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() > 0 || req_valid) @(negedge clock);
      while (expected_rsps.size() > 0) @(negedge clock);
      repeat (SLOT_COUNT + 8) @(posedge clock);

      $display("Covered %0d requests, %0d responses checked, %0d task switches",
               reqs_accepted, rsps_checked, switches_seen);
      $display("Status mix: ok %0d, full %0d, none runnable %0d, slot free %0d; %0d mismatches",
               status_seen[STS_OK], status_seen[STS_FULL], status_seen[STS_NONE],
               status_seen[STS_FREE], mismatches);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("round_robin_sleep_scheduler_core verification clean");
      end else begin
         $display("round_robin_sleep_scheduler_core verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("Timeout: %0d responses still outstanding", expected_rsps.size());
      $display("round_robin_sleep_scheduler_core verification failed");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/rrss_pkg.sv
hdl/rrss_ctrl.sv
hdl/rrss_dpath.sv
hdl/round_robin_sleep_scheduler_core.sv
tb/tb_round_robin_sleep_scheduler_core.sv
